/* hdl/ilp_pkg.sv */
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, constants and suffix table for the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int WIN_DEPTH = 5;
  localparam int SFX_COUNT = 12;
  localparam int VALUE_W   = 64;

  typedef logic [7:0] char_t;

  // radix codes as reported on the result
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [3:0] SFX_NONE = 4'd0;

  // suffix text right-aligned: last character in the low byte
  localparam logic [39:0] SFX_TEXT [SFX_COUNT] = '{
    40'("i128"), 40'("u128"), 40'("isize"), 40'("usize"),
    40'("i64"),  40'("u64"),  40'("i32"),   40'("u32"),
    40'("i16"),  40'("u16"),  40'("i8"),    40'("u8")
  };

  localparam logic [2:0] SFX_LEN [SFX_COUNT] = '{
    3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2
  };

  // controller to datapath commands
  typedef struct packed {
    logic load;    // take a character into the hold window
    logic match;   // pick the suffix and set up the flush
    logic flush;   // one flush step
    logic finish;  // resolve a lone first character
    logic emit;    // capture the result and clear the state
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic keep_zero;  // no held character left to feed
  } dp_stat_t;

  // suffix match on the hold window, lowest table entry wins; slot 4 is the newest
  function automatic logic [3:0] sfx_match(input logic [4:0][7:0] win,
                                           input logic [2:0] fill);
    logic [3:0] code;
    logic       hit;
    code = SFX_NONE;
    for (int k = SFX_COUNT - 1; k >= 0; k--) begin
      hit = (fill >= SFX_LEN[k]);
      for (int j = 0; j < WIN_DEPTH; j++) begin
        if ((3'(j) < SFX_LEN[k]) && (win[WIN_DEPTH - 1 - j] != SFX_TEXT[k][8*j +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        code = 4'(k + 1);
      end
    end
    return code;
  endfunction

  // length of the suffix picked by code, zero for none
  function automatic logic [2:0] sfx_len(input logic [3:0] code);
    logic [2:0] len;
    len = 3'd0;
    for (int k = 0; k < SFX_COUNT; k++) begin
      if (code == 4'(k + 1)) begin
        len = SFX_LEN[k];
      end
    end
    return len;
  endfunction

endpackage

/* hdl/ilp_char_if.sv */
// ----------------------------------------------------------------------------
// ilp_char_if
// Character channel: one literal character per beat, flag on the last one.
// ----------------------------------------------------------------------------
interface ilp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

/* hdl/ilp_result_if.sv */
// ----------------------------------------------------------------------------
// ilp_result_if
// Result channel: one parsed literal per beat.
// ----------------------------------------------------------------------------
interface ilp_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        valid_res;
  logic [1:0]  radix_code;
  logic [3:0]  suffix_code;

  modport source (output valid, output value, output valid_res, output radix_code,
                  output suffix_code, input ready);
  modport sink   (input valid, input value, input valid_res, input radix_code,
                  input suffix_code, output ready);
endinterface

/* hdl/int_literal_parser.sv */
// ----------------------------------------------------------------------------
// int_literal_parser
// Integer literal parser with 0b/0o/0x prefixes and a stripped type suffix.
// ----------------------------------------------------------------------------
// Characters come in one beat each and are taken one per cycle while the
// sequencer is idle; the five newest are held back and only the oldest goes
// through the parse unit. After the last character the sequencer matches the
// suffix, runs flush steps that pass the empty window slots and feed each
// held character that is not suffix, settles a lone first character and
// loads the result register, waiting while an earlier result beat is pending.
// There is a single parse unit, one character per cycle. A waiting result
// does not block the next literal's characters. Decimal values that exceed
// VALUE_BITS bits are rejected; prefixed values wrap at VALUE_BITS bits.
module int_literal_parser #(
  parameter int VALUE_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ilp_char_if.sink     in_i,
  ilp_result_if.source res_o
);
  import ilp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ilp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.is_last),
    .in_ready_o  (in_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // window, parse unit and result register
  ilp_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .char_i        (in_i.char_code),
    .value_o       (res_o.value),
    .valid_res_o   (res_o.valid_res),
    .radix_code_o  (res_o.radix_code),
    .suffix_code_o (res_o.suffix_code)
  );

endmodule

/* hdl/ilp_ctrl.sv */
// ----------------------------------------------------------------------------
// ilp_ctrl
// Sequencer: takes characters, then runs match, flush, finish and emit.
// ----------------------------------------------------------------------------
module ilp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output ilp_pkg::dp_cmd_t  cmd_o,
  input  ilp_pkg::dp_stat_t stat_i
);
  import ilp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_FLUSH  = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (stat_i.keep_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.flush = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result beat pending flag
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/ilp_datapath.sv */
// ----------------------------------------------------------------------------
// ilp_datapath
// Hold window, prefix detection, digit accumulator and result register.
// ----------------------------------------------------------------------------
module ilp_datapath #(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ilp_pkg::dp_cmd_t  cmd_i,
  output ilp_pkg::dp_stat_t stat_o,
  input  ilp_pkg::char_t    char_i,
  output logic [63:0]       value_o,
  output logic              valid_res_o,
  output logic [1:0]        radix_code_o,
  output logic [3:0]        suffix_code_o
);
  import ilp_pkg::*;

  localparam logic [2:0] FILL_FULL = 3'(WIN_DEPTH);

  // hold window, slot 4 newest
  logic [4:0][7:0] win_q, win_d;
  logic [2:0] fill_q, fill_d;
  logic [2:0] skip_q, skip_d;
  logic [2:0] keep_q, keep_d;
  logic [3:0] sfx_q, sfx_d;
  // parse state
  logic [1:0] consumed_q, consumed_d;
  char_t      pending_q, pending_d;
  logic [1:0] radix_q, radix_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic bad_q, bad_d, ovf_q, ovf_d, body_q, body_d;
  // result register
  logic [63:0] res_value_q;
  logic        res_ok_q;
  logic [1:0]  res_radix_q;
  logic [3:0]  res_sfx_q;

  logic [3:0] match_code;
  logic [2:0] match_len;
  char_t      fc;
  logic       feed_en;
  logic       c_dig, c_us, p_dig, p_us;
  char_t      c_off, c_aoff, c_Aoff, p_off;
  logic [4:0] hval;
  logic [6:0] two_dig;
  logic [VALUE_BITS+3:0] prod;
  logic       ok;
  logic [63:0] value_ext;

  assign match_code = sfx_match(win_q, fill_q);
  assign match_len  = sfx_len(match_code);

  // the character fed to the parse unit this cycle
  assign fc      = cmd_i.finish ? pending_q : win_q[0];
  assign feed_en = (cmd_i.load && (fill_q == FILL_FULL)) ||
                   (cmd_i.flush && (skip_q == 3'd0) && (keep_q != 3'd0)) ||
                   (cmd_i.finish && (consumed_q == 2'd1));

  // character classes and digit values
  always_comb begin
    c_off  = fc - char_t'("0");
    c_aoff = fc - char_t'("a");
    c_Aoff = fc - char_t'("A");
    p_off  = pending_q - char_t'("0");
    c_dig  = (fc >= char_t'("0")) && (fc <= char_t'("9"));
    c_us   = (fc == char_t'("_"));
    p_dig  = (pending_q >= char_t'("0")) && (pending_q <= char_t'("9"));
    p_us   = (pending_q == char_t'("_"));
    priority if (c_dig) begin
      hval = {1'b0, c_off[3:0]};
    end else if ((fc >= char_t'("a")) && (fc <= char_t'("f"))) begin
      hval = {1'b0, c_aoff[3:0]} + 5'd10;
    end else if ((fc >= char_t'("A")) && (fc <= char_t'("F"))) begin
      hval = {1'b0, c_Aoff[3:0]} + 5'd10;
    end else begin
      hval = 5'd16;
    end
    // first two decimal characters: at most 99, no overflow possible
    two_dig = p_dig ? 7'(p_off[3:0]) : 7'd0;
    if (c_dig) begin
      two_dig = 7'((two_dig << 3) + (two_dig << 1) + 7'(c_off[3:0]));
    end
    // times ten plus digit, with room to spot overflow
    prod = ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}) +
           (VALUE_BITS+4)'(c_off[3:0]);
  end

  // parse unit: one character per cycle
  always_comb begin
    consumed_d = consumed_q;
    pending_d  = pending_q;
    radix_d    = radix_q;
    acc_d      = acc_q;
    bad_d      = bad_q;
    ovf_d      = ovf_q;
    body_d     = body_q;
    if (feed_en) begin
      if (cmd_i.finish || ((consumed_q == 2'd2) && (radix_q == RADIX_DEC))) begin
        // decimal digit
        if (cmd_i.finish) begin
          radix_d = RADIX_DEC;
        end
        if (!c_us) begin
          if (!c_dig) begin
            bad_d = 1'b1;
          end else begin
            body_d = 1'b1;
            if (!ovf_q) begin
              if (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = prod[VALUE_BITS-1:0];
              end
            end
          end
        end
      end else if (consumed_q == 2'd2) begin
        // prefixed digit
        body_d = 1'b1;
        if (!c_us) begin
          unique case (radix_q)
            RADIX_BIN: begin
              if (hval > 5'd1) bad_d = 1'b1;
              else acc_d = {acc_q[VALUE_BITS-2:0], hval[0]};
            end
            RADIX_OCT: begin
              if (hval > 5'd7) bad_d = 1'b1;
              else acc_d = {acc_q[VALUE_BITS-4:0], hval[2:0]};
            end
            default: begin
              if (hval > 5'd15) bad_d = 1'b1;
              else acc_d = {acc_q[VALUE_BITS-5:0], hval[3:0]};
            end
          endcase
        end
      end else if (consumed_q == 2'd0) begin
        pending_d  = fc;
        consumed_d = 2'd1;
      end else begin
        // second character decides the prefix
        consumed_d = 2'd2;
        if ((pending_q == char_t'("0")) && ((fc == char_t'("b")) || (fc == char_t'("B")))) begin
          radix_d = RADIX_BIN;
        end else if ((pending_q == char_t'("0")) &&
                     ((fc == char_t'("o")) || (fc == char_t'("O")))) begin
          radix_d = RADIX_OCT;
        end else if ((pending_q == char_t'("0")) &&
                     ((fc == char_t'("x")) || (fc == char_t'("X")))) begin
          radix_d = RADIX_HEX;
        end else begin
          radix_d = RADIX_DEC;
          bad_d   = bad_q || (!p_dig && !p_us) || (!c_dig && !c_us);
          body_d  = body_q || p_dig || c_dig;
          acc_d   = VALUE_BITS'(two_dig);
        end
      end
    end
  end

  // hold window and flush counters
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    skip_d = skip_q;
    keep_d = keep_q;
    sfx_d  = sfx_q;
    if (cmd_i.load) begin
      win_d[3:0] = win_q[4:1];
      win_d[4]   = char_i;
      fill_d     = (fill_q == FILL_FULL) ? FILL_FULL : fill_q + 3'd1;
    end
    if (cmd_i.match) begin
      sfx_d  = match_code;
      keep_d = fill_q - match_len;
      skip_d = FILL_FULL - fill_q;
    end
    if (cmd_i.flush) begin
      win_d[3:0] = win_q[4:1];
      if (skip_q != 3'd0) begin
        skip_d = skip_q - 3'd1;
      end else if (keep_q != 3'd0) begin
        keep_d = keep_q - 3'd1;
      end
    end
  end

  assign stat_o.keep_zero = (keep_q == 3'd0);

  // result fields
  always_comb begin
    ok        = (consumed_q != 2'd0) && !bad_q && !ovf_q && body_q;
    value_ext = '0;
    value_ext[VALUE_BITS-1:0] = acc_q;
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.emit) begin
      res_value_q <= ok ? value_ext : 64'd0;
      res_ok_q    <= ok;
      res_radix_q <= radix_q;
      res_sfx_q   <= sfx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      skip_q     <= '0;
      keep_q     <= '0;
      sfx_q      <= SFX_NONE;
      consumed_q <= '0;
      pending_q  <= '0;
      radix_q    <= RADIX_DEC;
      acc_q      <= '0;
      bad_q      <= 1'b0;
      ovf_q      <= 1'b0;
      body_q     <= 1'b0;
    end else if (cmd_i.emit) begin
      fill_q     <= '0;
      skip_q     <= '0;
      keep_q     <= '0;
      sfx_q      <= SFX_NONE;
      consumed_q <= '0;
      pending_q  <= '0;
      radix_q    <= RADIX_DEC;
      acc_q      <= '0;
      bad_q      <= 1'b0;
      ovf_q      <= 1'b0;
      body_q     <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      skip_q     <= skip_d;
      keep_q     <= keep_d;
      sfx_q      <= sfx_d;
      consumed_q <= consumed_d;
      pending_q  <= pending_d;
      radix_q    <= radix_d;
      acc_q      <= acc_d;
      bad_q      <= bad_d;
      ovf_q      <= ovf_d;
      body_q     <= body_d;
    end
  end

  assign value_o       = res_value_q;
  assign valid_res_o   = res_ok_q;
  assign radix_code_o  = res_radix_q;
  assign suffix_code_o = res_sfx_q;

endmodule
